// ===== design/nbpsu_pkg.sv =====
// shared types and constants for the nnls pivot set update block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package nbpsu_pkg;

    localparam int MASK_W   = 16;
    localparam int COUNT_W  = 5;
    localparam int BACKUP_W = 3;
    localparam int CMD_W    = 2;
    localparam int COL_W    = 6;
    localparam int RULE_W   = 2;
    localparam int MAX_COLS = 64;

    // backup counter value loaded by init
    localparam logic [BACKUP_W-1:0] INIT_BACKUP = 3'd3;
    // backup limit after reset
    localparam logic [BACKUP_W-1:0] RESET_BACKUP_LIMIT = 3'd3;

    typedef enum logic [CMD_W-1:0] {
        CMD_INIT  = 2'd0,
        CMD_CHECK = 2'd1,
        CMD_PIVOT = 2'd2
    } cmd_t;

    typedef enum logic [RULE_W-1:0] {
        RULE_NONE     = 2'd0,
        RULE_IMPROVED = 2'd1,
        RULE_BACKUP   = 2'd2,
        RULE_FLIP     = 2'd3
    } rule_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    // per-column bookkeeping word held in the column memory
    typedef struct packed {
        logic [MASK_W-1:0]   passive;
        logic [MASK_W-1:0]   nonopt;
        logic [MASK_W-1:0]   infeas;
        logic [BACKUP_W-1:0] backup;
        logic [COUNT_W-1:0]  best_bad;
        logic [COUNT_W-1:0]  bad;
    } col_state_t;

    localparam int COL_STATE_W = $bits(col_state_t);

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic commit;
    } ctrl_cmd_t;

endpackage

`default_nettype wire

// ===== design/nbpsu_ram.sv =====
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module nbpsu_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/nbpsu_ctrl.sv =====
// handshake controller for the pivot set update block
// depends on nbpsu_pkg
`timescale 1ns / 1ps
`default_nettype none

module nbpsu_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output nbpsu_pkg::ctrl_cmd_t      cmd
);

    nbpsu_pkg::state_t state_reg;
    nbpsu_pkg::state_t state_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_free;

    // output slot is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nbpsu_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = nbpsu_pkg::S_EXEC;
                end
            end
            nbpsu_pkg::S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = nbpsu_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = nbpsu_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd.accept = 1'b0;
        cmd.commit = 1'b0;
        case (state_reg)
            nbpsu_pkg::S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            nbpsu_pkg::S_EXEC:
            begin
                cmd.commit = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nbpsu_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== design/nbpsu_dp.sv =====
// datapath: column memory, exchange rules and result register
// depends on nbpsu_pkg and nbpsu_ram
`timescale 1ns / 1ps
`default_nettype none

module nbpsu_dp #(
    parameter int K_VARS = 16,
    parameter int N_COLS = 64
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire nbpsu_pkg::ctrl_cmd_t             cmd,
    input  wire logic                             cfg_we,
    input  wire logic [nbpsu_pkg::BACKUP_W-1:0]   cfg_wdata,
    input  wire logic [nbpsu_pkg::CMD_W-1:0]      command,
    input  wire logic [nbpsu_pkg::COL_W-1:0]      column,
    input  wire logic [nbpsu_pkg::MASK_W-1:0]     x_positive_mask,
    input  wire logic [nbpsu_pkg::MASK_W-1:0]     x_negative_mask,
    input  wire logic [nbpsu_pkg::MASK_W-1:0]     y_negative_mask,
    output logic      [nbpsu_pkg::MASK_W-1:0]     passive_mask,
    output logic      [nbpsu_pkg::COUNT_W-1:0]    bad_count,
    output logic                                  column_not_good,
    output logic      [nbpsu_pkg::RULE_W-1:0]     rule_used,
    output logic                                  column_all_zero
);

    localparam int EFF_VARS = (K_VARS < nbpsu_pkg::MASK_W) ? K_VARS : nbpsu_pkg::MASK_W;
    localparam logic [nbpsu_pkg::MASK_W-1:0] VAR_MASK =
        nbpsu_pkg::MASK_W'((33'd1 << EFF_VARS) - 33'd1);
    localparam logic [nbpsu_pkg::COUNT_W-1:0] INIT_BEST =
        nbpsu_pkg::COUNT_W'(EFF_VARS + 1);
    localparam int DEPTH  = (N_COLS < nbpsu_pkg::MAX_COLS) ? N_COLS : nbpsu_pkg::MAX_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    function automatic logic [nbpsu_pkg::COUNT_W-1:0] count_ones(
        input logic [nbpsu_pkg::MASK_W-1:0] v
    );
        logic [nbpsu_pkg::COUNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < nbpsu_pkg::MASK_W; i++)
        begin
            n = n + nbpsu_pkg::COUNT_W'(v[i]);
        end
        return n;
    endfunction

    // config register
    logic [nbpsu_pkg::BACKUP_W-1:0] backup_limit_reg;

    // latched item
    logic [nbpsu_pkg::CMD_W-1:0]  cmd_reg;
    logic                         in_range_reg;
    logic [ADDR_W-1:0]            addr_reg;
    logic [nbpsu_pkg::MASK_W-1:0] xpos_reg;
    logic [nbpsu_pkg::MASK_W-1:0] xneg_reg;
    logic [nbpsu_pkg::MASK_W-1:0] yneg_reg;

    // result register
    logic [nbpsu_pkg::MASK_W-1:0]  passive_reg;
    logic [nbpsu_pkg::COUNT_W-1:0] bad_reg;
    logic                          not_good_reg;
    logic [nbpsu_pkg::RULE_W-1:0]  rule_reg;
    logic                          all_zero_reg;

    nbpsu_pkg::col_state_t         cur_st;
    nbpsu_pkg::col_state_t         new_st;
    logic [nbpsu_pkg::COL_STATE_W-1:0] rd_word;
    logic                          do_write;
    nbpsu_pkg::rule_t              rule;
    logic                          all_zero;
    logic [nbpsu_pkg::MASK_W-1:0]  no_m;
    logic [nbpsu_pkg::MASK_W-1:0]  inf_m;
    logic [nbpsu_pkg::MASK_W-1:0]  any_bad;
    logic [nbpsu_pkg::MASK_W-1:0]  flip_sel;
    logic [ADDR_W-1:0]             rd_addr;

    assign rd_addr = column[ADDR_W-1:0];
    assign cur_st  = nbpsu_pkg::col_state_t'(rd_word);

    nbpsu_ram #(
        .WIDTH (nbpsu_pkg::COL_STATE_W),
        .DEPTH (DEPTH),
        .ADDR_W(ADDR_W)
    ) u_col_ram (
        .clk  (clk),
        .we   (cmd.commit && do_write),
        .waddr(addr_reg),
        .wdata(new_st),
        .re   (cmd.accept),
        .raddr(rd_addr),
        .rdata(rd_word)
    );

    // masks for check
    assign no_m  = yneg_reg & ~cur_st.passive & VAR_MASK;
    assign inf_m = xneg_reg & cur_st.passive & VAR_MASK;

    // highest-numbered bad variable, one-hot
    assign any_bad = (cur_st.nonopt | cur_st.infeas) & VAR_MASK;
    always_comb
    begin
        flip_sel = '0;
        for (int k = 0; k < EFF_VARS; k++)
        begin
            if (any_bad[k])
            begin
                flip_sel    = '0;
                flip_sel[k] = 1'b1;
            end
        end
    end

    always_comb
    begin
        new_st   = cur_st;
        do_write = 1'b0;
        rule     = nbpsu_pkg::RULE_NONE;
        all_zero = 1'b0;
        if (in_range_reg)
        begin
            case (cmd_reg)
                nbpsu_pkg::CMD_INIT:
                begin
                    do_write        = 1'b1;
                    new_st.passive  = xpos_reg;
                    new_st.nonopt   = '0;
                    new_st.infeas   = '0;
                    new_st.bad      = 5'd1;
                    new_st.backup   = nbpsu_pkg::INIT_BACKUP;
                    new_st.best_bad = INIT_BEST;
                    all_zero        = ((xpos_reg | xneg_reg) == '0);
                end
                nbpsu_pkg::CMD_CHECK:
                begin
                    do_write = 1'b1;
                    if (cur_st.bad != '0)
                    begin
                        new_st.nonopt = no_m;
                        new_st.infeas = inf_m;
                        new_st.bad    = count_ones(no_m) + count_ones(inf_m);
                    end
                    else
                    begin
                        new_st.nonopt = '0;
                        new_st.infeas = '0;
                        new_st.bad    = '0;
                    end
                end
                nbpsu_pkg::CMD_PIVOT:
                begin
                    do_write = 1'b1;
                    if (cur_st.bad != '0)
                    begin
                        if (cur_st.bad < cur_st.best_bad)
                        begin
                            rule            = nbpsu_pkg::RULE_IMPROVED;
                            new_st.backup   = backup_limit_reg;
                            new_st.best_bad = cur_st.bad;
                            new_st.passive  = ((cur_st.passive & ~cur_st.infeas)
                                               | cur_st.nonopt) & VAR_MASK;
                        end
                        else if (cur_st.backup != '0)
                        begin
                            rule           = nbpsu_pkg::RULE_BACKUP;
                            new_st.backup  = cur_st.backup - 3'd1;
                            new_st.passive = ((cur_st.passive & ~cur_st.infeas)
                                              | cur_st.nonopt) & VAR_MASK;
                        end
                        else
                        begin
                            rule           = nbpsu_pkg::RULE_FLIP;
                            new_st.passive = cur_st.passive ^ flip_sel;
                        end
                    end
                end
                default:
                begin
                    do_write = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            backup_limit_reg <= nbpsu_pkg::RESET_BACKUP_LIMIT;
        end
        else if (cfg_we)
        begin
            backup_limit_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cmd_reg      <= command;
            in_range_reg <= (int'(column) < N_COLS);
            addr_reg     <= rd_addr;
            xpos_reg     <= x_positive_mask & VAR_MASK;
            xneg_reg     <= x_negative_mask & VAR_MASK;
            yneg_reg     <= y_negative_mask & VAR_MASK;
        end
        if (cmd.commit)
        begin
            passive_reg  <= do_write ? new_st.passive : '0;
            bad_reg      <= do_write ? new_st.bad : '0;
            not_good_reg <= do_write && (new_st.bad != '0);
            rule_reg     <= rule;
            all_zero_reg <= all_zero;
        end
    end

    assign passive_mask    = passive_reg;
    assign bad_count       = bad_reg;
    assign column_not_good = not_good_reg;
    assign rule_used       = rule_reg;
    assign column_all_zero = all_zero_reg;

endmodule

`default_nettype wire

// ===== design/nnls_block_pivot_set_update_core.sv =====
// top level of the nnls block pivoting set update core
// depends on nbpsu_pkg, nbpsu_ctrl, nbpsu_dp, nbpsu_ram
//
// usage:
//   input channel in_valid/in_ready carries one command beat (init, check or
//   pivot) for one column; output channel out_valid/out_ready returns exactly
//   one result beat per command, in order.
//   cfg_we/cfg_wdata writes the backup limit; write only while idle.
//   a beat is latched and its column memory word read as it is accepted; the
//   rule is then applied and the result registered on the outputs once the
//   output register is free.
//   because of the read-modify-write of the column memory, no new beat is
//   taken while one sits in the rule stage.
//   when the receiver stalls, the result waits in the output register; the
//   next command is still accepted and waits in the rule stage until the
//   output register drains.
//   reset clears the handshake state and sets the backup limit to 3; the
//   column memory is not cleared, so every column needs an init command
//   before check or pivot.
//   commands to columns at or above N_COLS, or unused command codes, return
//   an all-zero result and change nothing.
`timescale 1ns / 1ps
`default_nettype none

module nnls_block_pivot_set_update_core #(
    parameter int K_VARS = 16,
    parameter int N_COLS = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [nbpsu_pkg::BACKUP_W-1:0] cfg_wdata,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [nbpsu_pkg::CMD_W-1:0]    command,
    input  wire logic [nbpsu_pkg::COL_W-1:0]    column,
    input  wire logic [nbpsu_pkg::MASK_W-1:0]   x_positive_mask,
    input  wire logic [nbpsu_pkg::MASK_W-1:0]   x_negative_mask,
    input  wire logic [nbpsu_pkg::MASK_W-1:0]   y_negative_mask,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic      [nbpsu_pkg::MASK_W-1:0]   passive_mask,
    output logic      [nbpsu_pkg::COUNT_W-1:0]  bad_count,
    output logic                                column_not_good,
    output logic      [nbpsu_pkg::RULE_W-1:0]   rule_used,
    output logic                                column_all_zero
);

    nbpsu_pkg::ctrl_cmd_t ctrl_cmd;

    nbpsu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .cmd      (ctrl_cmd)
    );

    nbpsu_dp #(
        .K_VARS(K_VARS),
        .N_COLS(N_COLS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (ctrl_cmd),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .command        (command),
        .column         (column),
        .x_positive_mask(x_positive_mask),
        .x_negative_mask(x_negative_mask),
        .y_negative_mask(y_negative_mask),
        .passive_mask   (passive_mask),
        .bad_count      (bad_count),
        .column_not_good(column_not_good),
        .rule_used      (rule_used),
        .column_all_zero(column_all_zero)
    );

endmodule

`default_nettype wire
